[rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);
`else
`define ASSERT_HOLDS(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

[rtl/jsve_pkg.sv]
package jsve_pkg;

	localparam int KeyMaxDefault = 16;
	localparam int KeySlots = 16;
	localparam int KeyIdxW = 4;
	localparam int LimitW = 16;
	localparam int KeyLenW = 5;
	localparam int CfgDataW = 64;
	localparam int CfgIdxW = 2;

	localparam logic [7:0] ChColon = 8'h3a;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChBackslash = 8'h5c;
	localparam logic [7:0] ChTab = 8'h09;
	localparam logic [7:0] ChLf = 8'h0a;
	localparam logic [7:0] ChCr = 8'h0d;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChNul = 8'h00;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_LO    = 2'd0,
		REG_KEY_HI    = 2'd1,
		REG_KEY_LEN   = 2'd2,
		REG_OUT_LIMIT = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		PH_SEARCH = 5'b00001,
		PH_COLON  = 5'b00010,
		PH_QUOTE  = 5'b00100,
		PH_COPY   = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	// What a window cell reports about the byte it holds.
	typedef struct packed {
		logic is_quote;
		logic key_eq;
	} cell_stat_t;

	typedef struct packed {
		logic [7:0] value_char;
		logic       char_valid;
		logic       done_res;
		logic       found;
	} res_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == ChSpace) || (b == ChTab) || (b == ChLf) || (b == ChCr);
	endfunction

endpackage

[rtl/jsve_text_if.sv]
interface jsve_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source(output valid, text_byte, last_byte, input ready);
	modport sink(input valid, text_byte, last_byte, output ready);
endinterface

[rtl/jsve_result_if.sv]
interface jsve_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] value_char;
	logic       char_valid;
	logic       done_res;
	logic       found;

	modport source(output valid, value_char, char_valid, done_res, found, input ready);
	modport sink(input valid, value_char, char_valid, done_res, found, output ready);
endinterface

[rtl/jsve_cell.sv]
module jsve_cell
	import jsve_pkg::*;
(
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] din,
	input  logic [7:0] key_ch,
	output logic [7:0] dout,
	output cell_stat_t stat
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	assign stat.is_quote = (byte_q == ChQuote);
	assign stat.key_eq = (byte_q == key_ch);

endmodule

[rtl/json_string_value_extractor.sv]
// Channel | Dir | Word fields                                   | Accepted when
// text    | in  | text_byte, last_byte                          | valid && ready
// result  | out | value_char, char_valid, done_res, found       | valid && ready
// cfg     | in  | cfg_index, cfg_data                           | cfg_wr_en
//
// One text byte is taken every cycle while ready; the key window is a row of
// byte cells that shift together and compare against the key in parallel, so
// each byte settles in the cycle it is accepted and its word is registered.
// A two-word output buffer lets the text side keep flowing while the result side
// stalls; text.ready drops only once both words are held.
// Reset is asynchronous; window cells hold payload only and are not cleared.
`include "assert_macros.svh"

module json_string_value_extractor
	import jsve_pkg::*;
#(
	parameter int KEY_MAX = KeyMaxDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	jsve_text_if.sink           text,
	jsve_result_if.source       result,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int Cells = KEY_MAX + 1;
	localparam int WinLen = KEY_MAX + 2;
	localparam int KLW = $clog2(KEY_MAX + 1);
	localparam int BSW = $clog2(KEY_MAX + 3);

	// Configuration.
	logic [63:0]        key_lo_q;
	logic [63:0]        key_hi_q;
	logic [KeyLenW-1:0] key_len_q;
	logic [LimitW-1:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
			key_len_q <= '0;
			limit_q <= LimitW'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY_LO:    key_lo_q <= cfg_data;
				REG_KEY_HI:    key_hi_q <= cfg_data;
				REG_KEY_LEN:   key_len_q <= cfg_data[KeyLenW-1:0];
				REG_OUT_LIMIT: limit_q <= cfg_data[LimitW-1:0];
				default:       ;
			endcase
		end
	end

	logic [7:0]     key_chars [KeySlots];
	logic [KLW-1:0] klen;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			key_chars[i] = key_lo_q[8*i +: 8];
			key_chars[i+8] = key_hi_q[8*i +: 8];
		end
	end

	assign klen = (key_len_q > KeyLenW'(KEY_MAX)) ? KLW'(KEY_MAX) : KLW'(key_len_q);

	// Text-side state.
	phase_t          phase_q, phase_d;
	logic            esc_q, esc_d;
	logic [LimitW-1:0] cnt_q, cnt_d;
	logic [BSW-1:0]  seen_q, seen_d, seen_inc;

	logic        txt_acc;
	logic        shift_en;
	logic [7:0]  b;
	logic        last;
	logic        match;
	res_t        res_d;
	logic        push, pop;

	assign b = text.text_byte;
	assign last = text.last_byte;

	// Window cells: cell 0 holds the newest byte. The cell j is compared with the
	// key character that must sit there for the key to end at the incoming quote.
	logic [7:0] cell_din [Cells];
	logic [7:0] cell_dout [Cells];
	logic [7:0] cell_key [Cells];
	cell_stat_t cell_stat [Cells];
	logic [Cells-1:0] eq_ok;

	for (genvar j = 0; j < Cells; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign cell_din[j] = b;
		end else begin : g_link
			assign cell_din[j] = cell_dout[j-1];
		end
		assign cell_key[j] = key_chars[KeyIdxW'(int'(klen) - 1 - j)];
		assign eq_ok[j] = cell_stat[j].key_eq || (j >= int'(klen));

		jsve_cell u_cell (
			.clk     (clk),
			.shift_en(shift_en),
			.din     (cell_din[j]),
			.key_ch  (cell_key[j]),
			.dout    (cell_dout[j]),
			.stat    (cell_stat[j])
		);
	end

	assign seen_inc = (seen_q == BSW'(WinLen)) ? seen_q : seen_q + BSW'(1);
	assign match = (b == ChQuote) && (seen_inc >= BSW'(klen) + BSW'(2))
		&& cell_stat[klen].is_quote && (&eq_ok);

	logic [LimitW:0] cnt_inc, cnt_inc2, lim_ext;
	assign cnt_inc = {1'b0, cnt_q} + (LimitW+1)'(1);
	assign cnt_inc2 = {1'b0, cnt_q} + (LimitW+1)'(2);
	assign lim_ext = {1'b0, limit_q};

	always_comb begin
		logic done, fnd, vld;
		done = 1'b0;
		fnd = 1'b0;
		vld = 1'b0;
		phase_d = phase_q;
		esc_d = esc_q;
		cnt_d = cnt_q;
		seen_d = seen_q;
		shift_en = 1'b0;
		if (phase_q != PH_DONE) begin
			if (limit_q == '0) begin
				done = 1'b1;
			end else if (phase_q == PH_COPY) begin
				if (cnt_inc >= lim_ext) begin
					done = 1'b1;
					fnd = 1'b1;
				end else if (b == ChNul) begin
					done = 1'b1;
					fnd = 1'b1;
				end else if (esc_q) begin
					esc_d = 1'b0;
					vld = 1'b1;
				end else if (b == ChBackslash) begin
					esc_d = 1'b1;
				end else if (b == ChQuote) begin
					done = 1'b1;
					fnd = 1'b1;
				end else begin
					vld = 1'b1;
				end
				if (vld) begin
					cnt_d = cnt_inc[LimitW-1:0];
					// The count before this byte stayed below the limit, so no wrap here.
					if (cnt_inc2 >= lim_ext) begin
						done = 1'b1;
						fnd = 1'b1;
					end
				end
			end else if (b == ChNul) begin
				done = 1'b1;
			end else if (phase_q == PH_SEARCH) begin
				shift_en = txt_acc;
				seen_d = seen_inc;
				if (match) begin
					phase_d = PH_COLON;
				end
			end else if (phase_q == PH_COLON) begin
				if (b == ChColon) begin
					phase_d = PH_QUOTE;
				end else if (!is_space(b)) begin
					done = 1'b1;
				end
			end else begin
				if (b == ChQuote) begin
					phase_d = PH_COPY;
					cnt_d = '0;
					esc_d = 1'b0;
					if (limit_q <= LimitW'(1)) begin
						done = 1'b1;
						fnd = 1'b1;
					end
				end else if (!is_space(b)) begin
					done = 1'b1;
				end
			end
			if (!done && last) begin
				done = 1'b1;
				fnd = (phase_d == PH_COPY);
			end
		end
		if (last) begin
			phase_d = PH_SEARCH;
			esc_d = 1'b0;
			cnt_d = '0;
			seen_d = '0;
		end else if (done) begin
			phase_d = PH_DONE;
		end
		res_d.value_char = vld ? b : 8'h00;
		res_d.char_valid = vld;
		res_d.done_res = done;
		res_d.found = done && fnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			esc_q <= 1'b0;
			cnt_q <= '0;
			seen_q <= '0;
		end else if (txt_acc) begin
			phase_q <= phase_d;
			esc_q <= esc_d;
			cnt_q <= cnt_d;
			seen_q <= seen_d;
		end
	end

	// Two-word output buffer: the head word drives the port, the skid word
	// catches a word produced while the head is stalled.
	res_t out_q, skid_q;
	logic ov_q, sv_q;

	assign text.ready = !sv_q;
	assign txt_acc = text.valid && text.ready;
	assign push = txt_acc && (res_d.char_valid || res_d.done_res);
	assign pop = ov_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (pop) begin
			if (sv_q) begin
				sv_q <= push;
			end else begin
				ov_q <= push;
			end
		end else if (push) begin
			if (!ov_q) begin
				ov_q <= 1'b1;
			end else begin
				sv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (sv_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res_d;
				end
			end else if (push) begin
				out_q <= res_d;
			end
		end else if (push) begin
			if (!ov_q) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

	assign result.valid = ov_q;
	assign result.value_char = out_q.value_char;
	assign result.char_valid = out_q.char_valid;
	assign result.done_res = out_q.done_res;
	assign result.found = out_q.found;

	`ASSERT_HOLDS(a_skid_behind_head, (sv_q |-> ov_q), "skid word held without a head word")
	`ASSERT_HOLDS(a_done_leaves_text, ((push && res_d.done_res) |=> (phase_q == PH_DONE || phase_q == PH_SEARCH)), "decided text kept running")
	`ASSERT_NEVER(a_copy_only, (push && res_d.char_valid && phase_q != PH_COPY), "value byte emitted outside copy")
	`ASSERT_NEVER(a_shift_search, (shift_en && phase_q != PH_SEARCH), "window shifted outside key search")

endmodule
